### src/dedup_packet_fifo_with_range_count_defines.svh
// assertion macros for the dedup packet fifo
// used by the top level; expects clk and rst_n in scope
`ifndef DEDUP_PACKET_FIFO_WITH_RANGE_COUNT_DEFINES_SVH
`define DEDUP_PACKET_FIFO_WITH_RANGE_COUNT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/dpf_pkg.sv
// shared types and constants for the dedup packet fifo
// no dependencies
package dpf_pkg;

  localparam int NODE_BITS = 18;
  localparam int TIME_BITS = 30;
  localparam int CFG_W     = 7;
  localparam int CNT_W     = 7;

  // operation codes
  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_FWD = 2'd1;
  localparam logic [1:0] FUNC_CNT = 2'd2;

  typedef struct packed {
    logic [1:0]           func;
    logic [NODE_BITS-1:0] source_id;
    logic [NODE_BITS-1:0] dest_id;
    logic [TIME_BITS-1:0] time_value;
    logic [TIME_BITS-1:0] range_end;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic                 fwd_valid;
    logic [NODE_BITS-1:0] fwd_source;
    logic [NODE_BITS-1:0] fwd_dest;
    logic [TIME_BITS-1:0] fwd_time;
    logic [CNT_W-1:0]     match_count;
  } out_item_t;

  typedef struct packed {
    logic [NODE_BITS-1:0] src;
    logic [NODE_BITS-1:0] dst;
    logic [TIME_BITS-1:0] tstamp;
  } slot_t;

endpackage

### src/dpf_store.sv
// packet slot memory: one write port, one registered read port
// depends on dpf_pkg
module dpf_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  dpf_pkg::slot_t  wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output dpf_pkg::slot_t  rd_data
);
  import dpf_pkg::*;

  slot_t mem [DEPTH];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/dpf_scan.sv
// shared compare unit: duplicate match and range count, one slot per cycle
// depends on dpf_pkg
module dpf_scan #(
  parameter int OCC_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             ent_vld,
  input  dpf_pkg::slot_t   entry,
  input  dpf_pkg::in_item_t query,
  output logic             dup_hit,
  output logic [OCC_W-1:0] count
);
  import dpf_pkg::*;

  logic             dup_r, dup_nxt;
  logic [OCC_W-1:0] cnt_r, cnt_nxt;
  logic             dst_eq, full_eq, in_range;

  // one comparator set, reused for every slot
  assign dst_eq   = (entry.dst == query.dest_id);
  assign full_eq  = dst_eq && (entry.src == query.source_id) &&
                    (entry.tstamp == query.time_value);
  assign in_range = dst_eq && (entry.tstamp >= query.time_value) &&
                    (entry.tstamp <= query.range_end);

  always_comb begin
    dup_nxt = dup_r;
    cnt_nxt = cnt_r;
    if (clear) begin
      dup_nxt = 1'b0;
      cnt_nxt = '0;
    end else if (ent_vld) begin
      dup_nxt = dup_r | full_eq;
      cnt_nxt = cnt_r + OCC_W'(in_range);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dup_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      dup_r <= dup_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign dup_hit = dup_r;
  assign count   = cnt_r;

endmodule

### src/dedup_packet_fifo_with_range_count.sv
// top level of the dedup packet fifo: sequencer, ring pointers, result register
// depends on dpf_pkg, dpf_store, dpf_scan and the assertion macro header
//
// usage
//  - input channel in_valid/in_ready/in_data carries one request beat:
//    add a packet, forward the oldest, or count packets to a destination
//    whose timestamp lies in an inclusive range
//  - output channel out_valid/out_ready/out_data returns exactly one result
//    beat per request, in request order
//  - cfg_wr_en/cfg_wr_data write the occupancy limit (0 acts as 1, values
//    above DEPTH act as DEPTH); write it only while the block is idle
//  - timing: a request walks the live slots through the single compare unit,
//    one slot per cycle, limited by the one memory read port; in_ready rises
//    together with out_valid, so one request is in flight at a time
//  - a buffer at its occupancy limit evicts its oldest packet on an accepted
//    add; a duplicate is rejected before any eviction
//  - reset (synchronous, active low) empties the buffer, sets the limit to 64
//    and drops any pending result; slot contents are not cleared
//  - if the receiver stalls, the result stays in the output register and the
//    finished request waits in its final step until the register frees up
`include "dedup_packet_fifo_with_range_count_defines.svh"

module dedup_packet_fifo_with_range_count #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dpf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dpf_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [dpf_pkg::CFG_W-1:0] cfg_wr_data
);
  import dpf_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int LIM_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  in_item_t         req_r, req_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [CFG_W-1:0] lim_r, lim_nxt;
  logic [OCC_W-1:0] idx_r, idx_nxt;
  logic [OCC_W-1:0] nscan_r, nscan_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  slot_t            fwd_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             accept, issue, fin_go, do_drop, dup_hit, scan_clear;
  logic [AW-1:0]    rd_addr, wr_addr, head_inc;
  logic [OCC_W-1:0] match_cnt;
  logic [LIM_W-1:0] lim_eff;
  slot_t            rd_data, wr_slot;

  // ring index wrap: the sum stays below twice DEPTH, so one subtract is enough
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [OCC_W-1:0] off);
    logic [AW:0] sum;
    sum = (AW+1)'(base) + (AW+1)'(off);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state_r == ST_IDLE);
  assign issue      = (state_r == ST_SCAN) && (idx_r < nscan_r);
  assign fin_go     = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign scan_clear = accept;
  assign rd_addr    = ring_add(head_r, idx_r);
  assign wr_addr    = ring_add(head_r, occ_r);
  assign head_inc   = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  // effective limit clamped into 1..DEPTH
  always_comb begin
    lim_eff = LIM_W'(lim_r);
    if (lim_r == '0) begin
      lim_eff = LIM_W'(1);
    end else if (LIM_W'(lim_r) > LIM_W'(DEPTH)) begin
      lim_eff = LIM_W'(DEPTH);
    end
  end

  // an add that is not a duplicate evicts the oldest when at or over the limit
  assign do_drop = (LIM_W'(occ_r) >= lim_eff);

  assign wr_slot = '{src: req_r.source_id, dst: req_r.dest_id, tstamp: req_r.time_value};

  dpf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (fin_go && (req_r.func == FUNC_ADD) && !dup_hit),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dpf_scan #(
    .OCC_W (OCC_W)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (scan_clear),
    .ent_vld (rd_pend_r),
    .entry   (rd_data),
    .query   (req_r),
    .dup_hit (dup_hit),
    .count   (match_cnt)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    lim_nxt       = cfg_wr_en ? cfg_wr_data : lim_r;
    idx_nxt       = idx_r;
    nscan_nxt     = nscan_r;
    rd_pend_nxt   = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt = in_data;
          idx_nxt = '0;
          // slots to walk: all live ones, the head only, or none
          if (in_data.func == FUNC_ADD || in_data.func == FUNC_CNT) begin
            nscan_nxt = occ_r;
          end else if (in_data.func == FUNC_FWD) begin
            nscan_nxt = OCC_W'(occ_r != '0);
          end else begin
            nscan_nxt = '0;
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_pend_nxt = issue;
        if (issue) begin
          idx_nxt = idx_r + OCC_W'(1);
        end else if (!rd_pend_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          unique case (req_r.func)
            FUNC_ADD: begin
              out_data_nxt.accepted = !dup_hit;
              if (!dup_hit) begin
                if (do_drop) begin
                  head_nxt = head_inc;
                end else begin
                  occ_nxt = occ_r + OCC_W'(1);
                end
              end
            end
            FUNC_FWD: begin
              if (occ_r != '0) begin
                out_data_nxt.fwd_valid  = 1'b1;
                out_data_nxt.fwd_source = fwd_r.src;
                out_data_nxt.fwd_dest   = fwd_r.dst;
                out_data_nxt.fwd_time   = fwd_r.tstamp;
                head_nxt = head_inc;
                occ_nxt  = occ_r - OCC_W'(1);
              end
            end
            FUNC_CNT: begin
              out_data_nxt.match_count = CNT_W'(match_cnt);
            end
            default: begin
              // unused code: nothing changes, all-zero result
            end
          endcase
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      lim_r       <= CFG_W'(64);
      idx_r       <= '0;
      nscan_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      lim_r       <= lim_nxt;
      idx_r       <= idx_nxt;
      nscan_r     <= nscan_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
    if (rd_pend_r) begin
      fwd_r <= rd_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // occupancy stays within the ring
  `DPF_ASSERT_NOW(a_occ_bound, 1'b1, occ_r <= OCC_W'(DEPTH), "occupancy above depth")
  // a read is only outstanding while walking slots
  `DPF_ASSERT_NOW(a_pend_scan, rd_pend_r, state_r == ST_SCAN, "read pending outside scan")
  // finishing a request always presents a result beat
  `DPF_ASSERT_NEXT(a_fin_out, fin_go, out_valid && in_ready, "finished request lost")
  // a result beat carries the fields of one operation only
  `DPF_ASSERT_NOW(a_one_op, out_valid_r,
    $countones({out_data_r.accepted, out_data_r.fwd_valid,
                out_data_r.match_count != '0}) <= 1, "result mixes operations")

endmodule
